// ===== rtl/pha_pkg.sv =====
`timescale 1ns / 1ps
package pha_pkg;
  localparam int unsigned TableDepthDefault = 16;
  localparam logic [31:0] WarnThresholdReset = 32'd1048576;
  localparam logic [15:0] IntervalSecReset = 16'd5;
  localparam logic [1:0] KindStatus = 2'd0;
  localparam logic [1:0] KindSrc = 2'd1;
  localparam logic [1:0] KindDst = 2'd2;
  localparam logic CfgWarn = 1'b0;
  localparam logic CfgInterval = 1'b1;

  typedef struct packed {
    logic [47:0] src_mac;
    logic [31:0] src_ip;
    logic [47:0] dst_mac;
    logic [31:0] dst_ip;
    logic [15:0] pkt_len;
    logic [31:0] time_sec;
  } pkt_t;

  typedef struct packed {
    logic [1:0] kind;
    logic warn_flag;
    logic table_full;
    logic [47:0] entry_mac;
    logic [31:0] entry_ip;
    logic [31:0] entry_bytes;
    logic last;
  } res_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction
endpackage

// ===== rtl/pha_front.sv =====
`timescale 1ns / 1ps
module pha_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  pha_pkg::pkt_t in_pkt,
  output logic q_valid,
  input  logic q_stall,
  output pha_pkg::pkt_t q_pkt
);
  pha_pkg::pkt_t buf0, buf1;
  logic [1:0] cnt;
  logic wr, rd;

  assign in_stall = cnt[1];
  assign wr = in_valid && !in_stall;
  assign q_valid = cnt != 2'd0;
  assign rd = q_valid && !q_stall;
  assign q_pkt = buf0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (rd) begin
      buf0 <= buf1;
      if (wr && cnt == 2'd1) buf0 <= in_pkt;
      if (wr && cnt == 2'd2) buf1 <= in_pkt;
    end else if (wr) begin
      if (cnt == 2'd0) buf0 <= in_pkt;
      else buf1 <= in_pkt;
    end
  end
endmodule

// ===== rtl/pha_back.sv =====
`timescale 1ns / 1ps
module pha_back #(
  parameter int unsigned TABLE_DEPTH = pha_pkg::TableDepthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic [31:0] warn_threshold,
  input  logic [15:0] interval_sec,
  input  logic q_valid,
  output logic q_stall,
  input  pha_pkg::pkt_t q_pkt,
  output logic out_valid,
  input  logic out_stall,
  output pha_pkg::res_t out_res
);
  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned UW = $clog2(TABLE_DEPTH + 1);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StStat = 2'd1;
  localparam logic [1:0] StDump = 2'd2;

  logic [79:0] skey [TABLE_DEPTH];
  logic [31:0] sbyt [TABLE_DEPTH];
  logic [79:0] dkey [TABLE_DEPTH];
  logic [31:0] dbyt [TABLE_DEPTH];
  logic [UW-1:0] sused, dused;
  logic [31:0] total, istart;
  logic started;
  logic [1:0] state;
  logic dump_pend, dump_side;
  logic [UW-1:0] didx;
  logic full_r, warn_r;

  logic [79:0] sk, dk;
  logic shit, dhit;
  logic [IW-1:0] sidx, didx_hit;
  logic [31:0] start_eff, total_next;
  logic out_free, take;
  logic dump_now, emit;
  logic [UW-1:0] cur_used;
  logic [IW-1:0] rix;

  assign sk = {q_pkt.src_mac, q_pkt.src_ip};
  assign dk = {q_pkt.dst_mac, q_pkt.dst_ip};

  always_comb begin
    shit = 1'b0; sidx = '0; dhit = 1'b0; didx_hit = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (UW'(i) < sused && skey[i] == sk) begin shit = 1'b1; sidx = IW'(i); end
      if (UW'(i) < dused && dkey[i] == dk) begin dhit = 1'b1; didx_hit = IW'(i); end
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign take = q_valid && state == StIdle;
  assign q_stall = state != StIdle;
  assign start_eff = started ? istart : q_pkt.time_sec;
  assign total_next = pha_pkg::sat_add(total, {16'd0, q_pkt.pkt_len});
  assign dump_now = (q_pkt.time_sec - start_eff) >= {16'd0, interval_sec};

  assign cur_used = dump_side ? dused : sused;
  assign rix = didx[IW-1:0];
  assign emit = out_free && (state == StStat || (state == StDump && didx < cur_used));

  always_ff @(posedge clk) begin
    if (take) begin
      if (shit) sbyt[sidx] <= pha_pkg::sat_add(sbyt[sidx], {16'd0, q_pkt.pkt_len});
      else if (sused < UW'(TABLE_DEPTH)) begin
        skey[sused[IW-1:0]] <= sk;
        sbyt[sused[IW-1:0]] <= {16'd0, q_pkt.pkt_len};
      end
      if (dhit) dbyt[didx_hit] <= pha_pkg::sat_add(dbyt[didx_hit], {16'd0, q_pkt.pkt_len});
      else if (dused < UW'(TABLE_DEPTH)) begin
        dkey[dused[IW-1:0]] <= dk;
        dbyt[dused[IW-1:0]] <= {16'd0, q_pkt.pkt_len};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sused <= '0; dused <= '0; total <= '0; istart <= '0; started <= 1'b0;
      state <= StIdle; out_valid <= 1'b0; dump_pend <= 1'b0; dump_side <= 1'b0;
      didx <= '0; full_r <= 1'b0; warn_r <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        StIdle: begin
          if (take) begin
            started <= 1'b1;
            istart <= dump_now ? q_pkt.time_sec : start_eff;
            total <= total_next;
            warn_r <= total_next >= warn_threshold;
            full_r <= (!shit && sused >= UW'(TABLE_DEPTH)) ||
                      (!dhit && dused >= UW'(TABLE_DEPTH));
            if (!shit && sused < UW'(TABLE_DEPTH)) sused <= sused + UW'(1);
            if (!dhit && dused < UW'(TABLE_DEPTH)) dused <= dused + UW'(1);
            dump_pend <= dump_now;
            state <= StStat;
          end
        end
        StStat: begin
          if (out_free) begin
            out_res <= '{kind: pha_pkg::KindStatus, warn_flag: warn_r,
                         table_full: full_r, entry_mac: '0, entry_ip: '0,
                         entry_bytes: '0, last: !dump_pend};
            dump_side <= 1'b0; didx <= '0;
            state <= dump_pend ? StDump : StIdle;
          end
        end
        StDump: begin
          if (didx >= cur_used) begin
            if (!dump_side) begin
              dump_side <= 1'b1; didx <= '0;
            end else begin
              sused <= '0; dused <= '0; state <= StIdle;
            end
          end else if (out_free) begin
            out_res.warn_flag <= 1'b0;
            out_res.table_full <= 1'b0;
            if (!dump_side) begin
              out_res.kind <= pha_pkg::KindSrc;
              {out_res.entry_mac, out_res.entry_ip} <= skey[rix];
              out_res.entry_bytes <= sbyt[rix];
              out_res.last <= ((didx + UW'(1)) == sused) && dused == '0;
            end else begin
              out_res.kind <= pha_pkg::KindDst;
              {out_res.entry_mac, out_res.entry_ip} <= dkey[rix];
              out_res.entry_bytes <= dbyt[rix];
              out_res.last <= (didx + UW'(1)) == dused;
            end
            didx <= didx + UW'(1);
          end
        end
        default: state <= StIdle;
      endcase
    end
  end
endmodule

// ===== rtl/per_host_byte_accounting.sv =====
`timescale 1ns / 1ps
// Per-host byte accounting.
// Input channel: one packet request per in_valid/in_stall handshake, fields
// src_mac, src_ip, dst_mac, dst_ip, pkt_len, time_sec.
// Output channel: result requests (out_valid/out_stall) with kind, flags,
// entry fields and last. Each packet yields one status result, and when the
// dump interval has elapsed, every source entry then every destination entry.
// A two-entry queue separates the input side from the table engine, so input
// keeps flowing while a result waits on a stalled receiver.
// Path: a status result is registered in the queue, then in the engine,
// then at the output once its input request is accepted.
// Per packet the engine runs an update step then a status step, taking no
// new packet until idle; a dump adds a step per entry plus switch and finish steps.
// Config: cfg_we with cfg_index 0 = warn_threshold, 1 = interval_sec; write
// only while idle.
// Reset (rst, synchronous): tables empty, total zero, interval not started,
// registers at defaults. With out_stall high, results hold and the engine
// and then the queue fill and raise in_stall.
module per_host_byte_accounting #(
  parameter int unsigned TABLE_DEPTH = pha_pkg::TableDepthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [31:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [47:0] src_mac,
  input  logic [31:0] src_ip,
  input  logic [47:0] dst_mac,
  input  logic [31:0] dst_ip,
  input  logic [15:0] pkt_len,
  input  logic [31:0] time_sec,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] kind,
  output logic warn_flag,
  output logic table_full,
  output logic [47:0] entry_mac,
  output logic [31:0] entry_ip,
  output logic [31:0] entry_bytes,
  output logic last
);
  logic [31:0] warn_threshold;
  logic [15:0] interval_sec;
  pha_pkg::pkt_t in_pkt, q_pkt;
  pha_pkg::res_t res;
  logic q_valid, q_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      warn_threshold <= pha_pkg::WarnThresholdReset;
      interval_sec <= pha_pkg::IntervalSecReset;
    end else if (cfg_we) begin
      if (cfg_index == pha_pkg::CfgWarn) warn_threshold <= cfg_data;
      else interval_sec <= cfg_data[15:0];
    end
  end

  assign in_pkt = '{src_mac: src_mac, src_ip: src_ip, dst_mac: dst_mac,
                    dst_ip: dst_ip, pkt_len: pkt_len, time_sec: time_sec};

  pha_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_pkt,
    .q_valid, .q_stall, .q_pkt
  );

  pha_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk, .rst, .warn_threshold, .interval_sec,
    .q_valid, .q_stall, .q_pkt, .out_valid, .out_stall, .out_res(res)
  );

  assign kind = res.kind;
  assign warn_flag = res.warn_flag;
  assign table_full = res.table_full;
  assign entry_mac = res.entry_mac;
  assign entry_ip = res.entry_ip;
  assign entry_bytes = res.entry_bytes;
  assign last = res.last;
endmodule

// ===== rtl/pha_checker.sv =====
`timescale 1ns / 1ps
module pha_checker (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [1:0] kind,
  input logic warn_flag,
  input logic table_full,
  input logic [31:0] entry_ip,
  input logic last
);
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(last))
    else $error("stalled result changed");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != pha_pkg::KindStatus |-> !warn_flag && !table_full)
    else $error("flags on entry result");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == pha_pkg::KindStatus |-> entry_ip == 32'd0)
    else $error("status carries entry");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> !(out_valid && kind == pha_pkg::KindStatus))
    else $error("new status before last");
  assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("busy after reset");
endmodule

bind per_host_byte_accounting pha_checker u_pha_checker (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .kind,
  .warn_flag, .table_full, .entry_ip, .last
);
